@@ sv/utf7d_pkg.sv @@
package utf7d_pkg;

  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] DASH_CHAR  = 8'h2D;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] NOT_DIGIT  = 8'hFF;

  // One queue entry: the results caused by one input byte.
  typedef struct packed {
    logic       two;         // second byte follows the first
    logic       incomplete;  // stream ended inside a group
    logic [7:0] first;
    logic [7:0] second;
  } entry_t;

  // Base64 digit value, or NOT_DIGIT for any other byte.
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = NOT_DIGIT;
    if (c >= 8'h41 && c <= 8'h5A) d = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) d = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30 + 8'd52;
    else if (c == PLUS_CHAR) d = 8'd62;
    else if (c == SLASH_CHAR) d = 8'd63;
    return d;
  endfunction

endpackage

@@ sv/utf7d_front.sv @@
module utf7d_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              end_of_stream,
  output logic              emit,
  output utf7d_pkg::entry_t entry
);
  import utf7d_pkg::*;

  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_GROUP  = 2'd2;

  logic [1:0]  shift_mode, shift_mode_next;
  logic [1:0]  digits_held, digits_held_next;
  logic [11:0] partial_value, partial_value_next;
  logic [7:0]  digit;
  logic [17:0] word;

  assign digit = digit_of(in_byte);
  assign word  = {partial_value, 6'b0} | {10'b0, digit};

  always_comb begin
    shift_mode_next    = shift_mode;
    digits_held_next   = digits_held;
    partial_value_next = partial_value;
    emit               = 1'b0;
    entry              = '0;
    if (shift_mode == MODE_DIRECT) begin
      if (in_byte == PLUS_CHAR) begin
        shift_mode_next = MODE_OPEN;
      end else begin
        emit        = 1'b1;
        entry.first = in_byte;
      end
    end else if (digits_held == 2'd0) begin
      if (in_byte == DASH_CHAR && shift_mode != MODE_OPEN) begin
        shift_mode_next = MODE_DIRECT;
      end else if (digit == NOT_DIGIT) begin
        shift_mode_next = MODE_DIRECT;
        emit            = 1'b1;
        entry.first     = in_byte;
      end else begin
        partial_value_next = {4'b0, digit};
        digits_held_next   = 2'd1;
      end
    end else if (digits_held == 2'd1) begin
      partial_value_next = {partial_value[5:0], 6'b0} | {4'b0, digit};
      digits_held_next   = 2'd2;
    end else begin
      emit = 1'b1;
      if (word <= 18'h000FF) begin
        entry.first = word[7:0];
      end else begin
        entry.two    = 1'b1;
        entry.first  = word[15:8];
        entry.second = word[7:0];
      end
      digits_held_next   = 2'd0;
      partial_value_next = '0;
      shift_mode_next    = MODE_GROUP;
    end
    if (end_of_stream) begin
      // an open group only arises from bytes that gave no result
      if (digits_held_next != 2'd0) begin
        emit             = 1'b1;
        entry            = '0;
        entry.incomplete = 1'b1;
      end
      shift_mode_next    = MODE_DIRECT;
      digits_held_next   = 2'd0;
      partial_value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_mode    <= MODE_DIRECT;
      digits_held   <= 2'd0;
      partial_value <= '0;
    end else if (accept) begin
      shift_mode    <= shift_mode_next;
      digits_held   <= digits_held_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

@@ sv/utf7d_fifo.sv @@
module utf7d_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  utf7d_pkg::entry_t wr_entry,
  input  logic              rd_en,
  output utf7d_pkg::entry_t head,
  output logic              empty,
  output logic              full
);
  import utf7d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr, do_rd;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/utf7d_back.sv @@
module utf7d_back (
  input  logic              clk,
  input  logic              rst,
  input  utf7d_pkg::entry_t head,
  input  logic              empty,
  input  logic              pop,
  output logic              retire,
  output logic [7:0]        out_byte,
  output logic              incomplete,
  output logic              last_of_run
);
  import utf7d_pkg::*;

  logic on_second;

  assign out_byte    = on_second ? head.second : head.first;
  assign incomplete  = head.incomplete;
  assign last_of_run = !head.two || on_second;
  assign retire      = pop && !empty && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_second <= 1'b0;
    end else if (pop && !empty) begin
      // advance to the second byte, or drop the entry
      on_second <= !last_of_run;
    end
  end

endmodule

@@ sv/utf7_style_decoder.sv @@
// Channel   Handshake          Fields
// input     push / full        in_byte[7:0], end_of_stream
// result    empty / pop        out_byte[7:0], incomplete, last_of_run
//
// One input byte is taken each cycle while full is low; its results, if any,
// are registered into the queue when it is accepted.
// A byte that gives two results holds one queue entry for two pops; the
// result side delivers one result a cycle while pop is high, so the
// FIFO_DEPTH-entry queue sets how long the input runs ahead of a
// stalled consumer. Reset (rst, synchronous) returns the decoder to
// direct mode and empties the queue.
module utf7_style_decoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       end_of_stream,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic       incomplete,
  output logic       last_of_run,
  output logic       empty,
  input  logic       pop
);
  import utf7d_pkg::*;

  logic   accept;
  logic   emit;
  logic   retire;
  entry_t new_entry;
  entry_t head;

  assign accept = push && !full;

  utf7d_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .emit          (emit),
    .entry         (new_entry)
  );

  utf7d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && emit),
    .wr_entry (new_entry),
    .rd_en    (retire),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  utf7d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .retire      (retire),
    .out_byte    (out_byte),
    .incomplete  (incomplete),
    .last_of_run (last_of_run)
  );

endmodule

@@ sv/utf7d_checker.sv @@
module utf7d_checker (
  input logic       clk,
  input logic       rst,
  input logic [7:0] in_byte,
  input logic       end_of_stream,
  input logic       push,
  input logic       full,
  input logic [7:0] out_byte,
  input logic       incomplete,
  input logic       last_of_run,
  input logic       empty,
  input logic       pop
);

  // the incomplete marker always stands alone with a zero byte
  a_incomplete_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && incomplete) |-> (out_byte == 8'h00 && last_of_run))
    else $error("incomplete result carries data or is not last");

  // nothing appears on the result side without an accepted byte
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (empty && !(push && !full)) |=> empty)
    else $error("result appeared without an accepted input");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queue not cleared by reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)))
    else $error("stalled result changed");

endmodule

bind utf7_style_decoder utf7d_checker u_chk (.*);
